/* hw/rtl/srd_pkg.sv */
`timescale 1ns / 1ps

package srd_pkg;

    // Largest line width and line count that the decoder is built for.
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_LINES_DEF = 2048;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 1'd1;

    localparam logic [12:0] LINE_WIDTH_RESET = 13'd720;
    localparam logic [11:0] LINE_COUNT_RESET = 12'd240;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       field_start;
        logic       buffer_last;
    } t_in_item;

    typedef struct packed {
        logic [11:0] run_start;
        logic [10:0] line_index;
        logic [12:0] run_length;
        logic [1:0]  pixel_color;
        logic        field_done;
        logic        out_of_data;
        logic        last;
    } t_out_item;

endpackage

/* hw/rtl/subpicture_rle_decoder.sv */
`timescale 1ns / 1ps

// Decodes the RLE bytes of one DVD subpicture field into runs of 2-bit color,
// each reported with its line, start column and length. A byte sits in the
// input register while both of its nibbles are decoded, and its results (up
// to two runs and an out-of-data status) are loaded into a three-entry
// result bank that drains one result per cycle onto the output while the
// output is not stalled. A byte is decoded only when the bank is empty or
// its last result is being taken, so the single output channel draining the
// bank sets the pace. The next byte is taken into the input register while
// results still wait. The first result of a byte is presented on the output
// once the byte has been decoded from the input register into the bank.
// Configuration writes take effect at once and should only be made while no
// request is in flight.
module subpicture_rle_decoder
    import srd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    input  t_in_item               i_in,
    output logic                   o_in_stall,

    output logic                   o_out_valid,
    output t_out_item              o_out,
    input  logic                   i_out_stall
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = $clog2(MAX_LINES + 1);

    typedef struct packed {
        logic [5:0]    accum;
        logic [1:0]    held;
        logic [CW-1:0] col;
        logic [LW-1:0] line;
        logic          finished;
    } t_dec_state;

    typedef struct packed {
        t_dec_state st;
        logic       emit;
        logic       line_end;
        t_out_item  res;
    } t_nib_step;

    function automatic t_nib_step f_nibble(t_dec_state s, logic [3:0] nib,
                                           logic [WW-1:0] w, logic [LW-1:0] h);
        t_nib_step     o;
        logic [9:0]    v;
        logic [7:0]    run;
        logic [2:0]    cnt;
        logic          complete;
        logic [WW-1:0] col_ext;
        logic [WW-1:0] rest;
        logic [WW-1:0] len;
        logic [WW-1:0] col_sum;
        logic [LW-1:0] line_nx;
        v        = {s.accum, nib};
        run      = v[9:2];
        cnt      = {1'b0, s.held} + 3'd1;
        o        = '0;
        o.st     = s;
        col_ext  = WW'(s.col);
        rest     = '0;
        len      = '0;
        col_sum  = '0;
        line_nx  = '0;
        case (cnt)
            3'd1:    complete = (v >= 10'h004);
            3'd2:    complete = (v >= 10'h010);
            3'd3:    complete = (v >= 10'h040);
            default: complete = 1'b1;
        endcase
        if (!complete) begin
            o.st.accum = v[5:0];
            o.st.held  = cnt[1:0];
        end else begin
            o.st.accum = '0;
            o.st.held  = '0;
            o.emit     = 1'b1;
            rest = (col_ext < w) ? (w - col_ext) : '0;
            // A code below four fills the rest of the line.
            if (v < 10'h004) begin
                len = rest;
            end else if (13'(run) > 13'(rest)) begin
                len = rest;
            end else begin
                len = WW'(run);
            end
            col_sum = col_ext + len;
            o.res.run_start   = 12'(s.col);
            o.res.line_index  = 11'(s.line);
            o.res.run_length  = 13'(len);
            o.res.pixel_color = v[1:0];
            if (col_sum >= w) begin
                o.line_end = 1'b1;
                line_nx    = s.line + 1'b1;
                o.st.line  = line_nx;
                o.st.col   = '0;
                if (line_nx >= h) begin
                    o.st.finished    = 1'b1;
                    o.res.field_done = 1'b1;
                end
            end else begin
                o.st.col = CW'(col_sum);
            end
        end
        return o;
    endfunction

    logic [12:0]   r_line_width;
    logic [11:0]   r_line_count;
    logic          r_in_valid;
    t_in_item      r_in;
    t_dec_state    r_state;
    t_out_item     r_bank [3];
    logic [1:0]    r_cnt;

    logic [WW-1:0] w_eff;
    logic [LW-1:0] h_eff;
    t_dec_state    s0;
    t_nib_step     step_hi;
    t_nib_step     step_lo;
    logic          emit_hi;
    logic          emit_lo;
    logic          emit_st;
    t_out_item     res_hi;
    t_out_item     res_lo;
    t_out_item     res_st;
    t_dec_state    n_state;
    t_out_item     n_bank [3];
    logic [1:0]    n_cnt;
    logic          out_take;
    logic          bank_free;
    logic          dec_go;
    logic          in_take;

    always_comb begin
        if (r_line_width == '0) begin
            w_eff = WW'(1);
        end else if (r_line_width > 13'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_line_width);
        end
        if (r_line_count == '0) begin
            h_eff = LW'(1);
        end else if (r_line_count > 12'(MAX_LINES)) begin
            h_eff = LW'(MAX_LINES);
        end else begin
            h_eff = LW'(r_line_count);
        end
    end

    // Both nibbles of the held byte are decoded in one pass; the low nibble
    // is skipped when the high one ends a line or the field.
    always_comb begin
        s0      = r_in.field_start ? '0 : r_state;
        step_hi = f_nibble(s0, r_in.data_byte[7:4], w_eff, h_eff);
        step_lo = f_nibble(step_hi.st, r_in.data_byte[3:0], w_eff, h_eff);
        emit_hi = !s0.finished && step_hi.emit;
        emit_lo = !s0.finished && !step_hi.st.finished && !step_hi.line_end
                  && step_lo.emit;
        n_state = s0;
        if (!s0.finished) begin
            if (!step_hi.st.finished && !step_hi.line_end) begin
                n_state = step_lo.st;
            end else begin
                n_state = step_hi.st;
            end
        end
        emit_st = !n_state.finished && r_in.buffer_last;
        if (emit_st) begin
            n_state.finished = 1'b1;
        end

        res_hi      = step_hi.res;
        res_hi.last = !emit_lo && !emit_st;
        res_lo      = step_lo.res;
        res_lo.last = !emit_st;
        res_st             = '0;
        res_st.out_of_data = 1'b1;
        res_st.last        = 1'b1;
    end

    assign out_take   = (r_cnt != 2'd0) && !i_out_stall;
    assign bank_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign dec_go     = r_in_valid && bank_free;
    assign o_in_stall = r_in_valid && !dec_go;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_bank[0];

    always_comb begin
        n_bank[0] = r_bank[0];
        n_bank[1] = r_bank[1];
        n_bank[2] = r_bank[2];
        n_cnt     = r_cnt;
        if (dec_go) begin
            n_bank[0] = emit_hi ? res_hi : (emit_lo ? res_lo : res_st);
            n_bank[1] = (emit_hi && emit_lo) ? res_lo : res_st;
            n_bank[2] = res_st;
            n_cnt     = 2'({1'b0, emit_hi} + {1'b0, emit_lo} + {1'b0, emit_st});
        end else if (out_take) begin
            n_bank[0] = r_bank[1];
            n_bank[1] = r_bank[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_line_count <= LINE_COUNT_RESET;
            r_in_valid   <= 1'b0;
            r_state      <= '0;
            r_cnt        <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                    CFG_LINE_COUNT: r_line_count <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (dec_go) begin
                r_in_valid <= 1'b0;
            end
            if (dec_go) begin
                r_state <= n_state;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        r_bank[0] <= n_bank[0];
        r_bank[1] <= n_bank[1];
        r_bank[2] <= n_bank[2];
    end

endmodule
